>>> sv/hk_pkg.sv
package hk_pkg;

    localparam int WORD_W     = 64;
    localparam int BLOCK_W    = 128;
    localparam int MSG_W      = 4 * WORD_W;
    localparam int MAX_ROUNDS = 5;
    localparam int HK_ROUNDS  = 5;
    localparam int NUM_RC     = 4 * MAX_ROUNDS;

    // One pipeline slot: the two AES halves plus the message kept for the feed-forward.
    typedef struct packed {
        logic [BLOCK_W-1:0] left;
        logic [BLOCK_W-1:0] right;
        logic [MSG_W-1:0]   msg;
    } hk_pipe_t;

    // Round constants as 128-bit keys, state byte i in bits 8i+7:8i.
    localparam logic [BLOCK_W-1:0] RC [NUM_RC] = '{
        128'h0684704c_e620c00a_b2c5fef0_75817b9d,
        128'h8b66b4e1_88f3a06b_640f6ba4_2f08f717,
        128'h3402de2d_53f28498_cf029d60_9f029114,
        128'h0ed6eae6_2e7b4f08_bbf3bcaf_fd5b4f79,
        128'hcbcfb0cb_4872448b_79eecd1c_be397044,
        128'h7eeacdee_6e9032b7_8d5335ed_2b8a057b,
        128'h67c28f43_5e2e7cd0_e2412761_da4fef1b,
        128'h2924d9b0_afcacc07_675ffde2_1fc70b3b,
        128'hab4d63f1_e6867fe9_ecdb8fca_b9d465ee,
        128'h1c30bf84_d4b7cd64_5b2a404f_ad037e33,
        128'hb2cc0bb9_941723bf_69028b2e_8df69800,
        128'hfa0478a6_de6f5572_4aaa9ec8_5c9d2d8a,
        128'hdfb49f2b_6b772a12_0efa4f2e_29129fd4,
        128'h1ea10344_f449a236_32d611ae_bb6a12ee,
        128'haf044988_4b050084_5f9600c9_9ca8eca6,
        128'h21025ed8_9d199c4f_78a2c7e3_27e593ec,
        128'hbf3aaaf8_a759c9b7_b9282ecd_82d40173,
        128'h6260700d_6186b017_37f2efd9_10307d6b,
        128'h5aca45c2_21300443_81c29153_f6fc9ac6,
        128'h9223973c_226b68bb_2caf92e8_36d1943a
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiplication by two in the AES field.
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

>>> sv/hk_msg_if.sv
interface hk_msg_if;
    import hk_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] msg_word0;
    logic [WORD_W-1:0] msg_word1;
    logic [WORD_W-1:0] msg_word2;
    logic [WORD_W-1:0] msg_word3;

    modport source (
        output valid, msg_word0, msg_word1, msg_word2, msg_word3,
        input  ready
    );

    modport sink (
        input  valid, msg_word0, msg_word1, msg_word2, msg_word3,
        output ready
    );

endinterface

>>> sv/hk_dig_if.sv
interface hk_dig_if;
    import hk_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word0;
    logic [WORD_W-1:0] digest_word1;
    logic [WORD_W-1:0] digest_word2;
    logic [WORD_W-1:0] digest_word3;

    modport source (
        output valid, digest_word0, digest_word1, digest_word2, digest_word3,
        input  ready
    );

    modport sink (
        input  valid, digest_word0, digest_word1, digest_word2, digest_word3,
        output ready
    );

endinterface

>>> sv/hk_aes_round.sv
module hk_aes_round #(
    parameter logic [hk_pkg::BLOCK_W-1:0] KEY = '0
) (
    input  logic [hk_pkg::BLOCK_W-1:0] st,
    output logic [hk_pkg::BLOCK_W-1:0] res
);
    import hk_pkg::*;

    logic [BLOCK_W-1:0] sh;

    // SubBytes and ShiftRows: byte i sits in row i%4, column i/4.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sh[8*i +: 8] = SBOX[st[8*((((i/4) + (i%4)) % 4)*4 + (i%4)) +: 8]];
        end
    end

    // MixColumns and the key addition, one column at a time.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            res[32*c +: 8] = xtime(sh[32*c +: 8]) ^ xtime(sh[32*c+8 +: 8])
                ^ sh[32*c+8 +: 8] ^ sh[32*c+16 +: 8] ^ sh[32*c+24 +: 8]
                ^ KEY[32*c +: 8];
            res[32*c+8 +: 8] = sh[32*c +: 8] ^ xtime(sh[32*c+8 +: 8])
                ^ xtime(sh[32*c+16 +: 8]) ^ sh[32*c+16 +: 8] ^ sh[32*c+24 +: 8]
                ^ KEY[32*c+8 +: 8];
            res[32*c+16 +: 8] = sh[32*c +: 8] ^ sh[32*c+8 +: 8]
                ^ xtime(sh[32*c+16 +: 8]) ^ xtime(sh[32*c+24 +: 8])
                ^ sh[32*c+24 +: 8] ^ KEY[32*c+16 +: 8];
            res[32*c+24 +: 8] = xtime(sh[32*c +: 8]) ^ sh[32*c +: 8]
                ^ sh[32*c+8 +: 8] ^ sh[32*c+16 +: 8] ^ xtime(sh[32*c+24 +: 8])
                ^ KEY[32*c+24 +: 8];
        end
    end

endmodule

>>> sv/hk_stage.sv
module hk_stage #(
    parameter logic [hk_pkg::BLOCK_W-1:0] KEY_L = '0,
    parameter logic [hk_pkg::BLOCK_W-1:0] KEY_R = '0,
    parameter bit                         MIX   = 1'b0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hk_pkg::hk_pipe_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hk_pkg::hk_pipe_t out_data
);
    import hk_pkg::*;

    logic               valid_reg;
    hk_pipe_t           data_reg;
    hk_pipe_t           data_next;
    logic [BLOCK_W-1:0] left_rnd;
    logic [BLOCK_W-1:0] right_rnd;

    hk_aes_round #(.KEY(KEY_L)) u_round_l (.st(in_data.left),  .res(left_rnd));
    hk_aes_round #(.KEY(KEY_R)) u_round_r (.st(in_data.right), .res(right_rnd));

    // The second half of a Haraka round interleaves the 32-bit columns.
    always_comb
    begin
        data_next.msg = in_data.msg;
        if (MIX)
        begin
            data_next.left  = {right_rnd[63:32], left_rnd[63:32],
                               right_rnd[31:0],  left_rnd[31:0]};
            data_next.right = {right_rnd[127:96], left_rnd[127:96],
                               right_rnd[95:64],  left_rnd[95:64]};
        end
        else
        begin
            data_next.left  = left_rnd;
            data_next.right = right_rnd;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> sv/haraka256_hash_top.sv
// Haraka v2 256-bit hash engine.
//
// A message word enters on msg_in: four 64-bit little-endian words, bytes
// 0-15 forming the left AES state and bytes 16-31 the right one. The digest
// word leaves on dig_out in the same word order. Both channels use a
// valid/ready handshake and a word moves on a clock edge with both high.
//
// The datapath is a pipeline of 2*ROUNDS register stages (ten by default).
// A ROUNDS value above five is held at five, since the constant table only
// covers five rounds. Each stage runs one keyed AES round on both halves
// side by side; every second stage also interleaves the 32-bit columns of
// the halves. The feed-forward XOR with the message, which travels down the
// pipe, is applied at the output of the last stage.
//
// Throughput is one word per cycle while the receiver does not stall, set by
// one AES round (S-box lookups and MixColumns) between registers. When the
// receiver stalls, each stage holds its word and only takes a new one once
// its own slot drains, so the pipe fills up before msg_in.ready drops. Reset
// empties all stages; digests still in flight are dropped.
module haraka256_hash_top #(
    parameter int ROUNDS = hk_pkg::HK_ROUNDS
) (
    input  logic     clk,
    input  logic     rst_n,
    hk_msg_if.sink   msg_in,
    hk_dig_if.source dig_out
);
    import hk_pkg::*;

    localparam int NSTAGE = 2 * ((ROUNDS < MAX_ROUNDS) ? ROUNDS : MAX_ROUNDS);

    // Link k feeds stage k; link NSTAGE is the output.
    logic     vld [NSTAGE+1];
    logic     rdy [NSTAGE+1];
    hk_pipe_t dat [NSTAGE+1];

    logic [MSG_W-1:0]   digest;

    assign vld[0]       = msg_in.valid;
    assign msg_in.ready = rdy[0];
    assign dat[0].left  = {msg_in.msg_word1, msg_in.msg_word0};
    assign dat[0].right = {msg_in.msg_word3, msg_in.msg_word2};
    assign dat[0].msg   = {msg_in.msg_word3, msg_in.msg_word2,
                           msg_in.msg_word1, msg_in.msg_word0};

    generate
        for (genvar s = 0; s < NSTAGE; s++)
        begin : g_stage
            localparam int RND = s / 2;
            localparam int PH  = s % 2;
            hk_stage #(
                .KEY_L (RC[4*RND + 2*PH]),
                .KEY_R (RC[4*RND + 2*PH + 1]),
                .MIX   (PH == 1)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (vld[s]),
                .in_ready  (rdy[s]),
                .in_data   (dat[s]),
                .out_valid (vld[s+1]),
                .out_ready (rdy[s+1]),
                .out_data  (dat[s+1])
            );
        end
    endgenerate

    // Feed-forward: the final state is XORed with the original message.
    assign digest = {dat[NSTAGE].right, dat[NSTAGE].left} ^ dat[NSTAGE].msg;

    assign rdy[NSTAGE]          = dig_out.ready;
    assign dig_out.valid        = vld[NSTAGE];
    assign dig_out.digest_word0 = digest[WORD_W-1:0];
    assign dig_out.digest_word1 = digest[2*WORD_W-1:WORD_W];
    assign dig_out.digest_word2 = digest[3*WORD_W-1:2*WORD_W];
    assign dig_out.digest_word3 = digest[4*WORD_W-1:3*WORD_W];

    // A ready receiver must let the whole pipe advance, with no bubble.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        dig_out.ready |-> msg_in.ready)
        else $error("input stalled while the output was ready");

    // An accepted word lands in the first stage.
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        msg_in.valid && msg_in.ready |=> vld[1])
        else $error("accepted word missing from the first stage");

    // The message carried for the feed-forward is the one that was accepted.
    a_msg_carry: assert property (@(posedge clk) disable iff (!rst_n)
        msg_in.valid && msg_in.ready |=> dat[1].msg == $past(dat[0].msg))
        else $error("feed-forward message corrupted in the first stage");

endmodule
